// ===== rtl/fst_pkg.sv =====
// ----------------------------------------------------------------------------
// fst_pkg: shared types and constants for the frame sequence timer
// Request and response words, field widths and parameter defaults.
// ----------------------------------------------------------------------------
package fst_pkg;

	localparam int unsigned MAX_FRAMES_DEF    = 16;
	localparam int unsigned DURATION_BITS_DEF = 16;

	localparam int unsigned ELAPSED_W  = 32;
	localparam int unsigned WINDEX_W   = 4;
	localparam int unsigned WDUR_W     = 16;
	localparam int unsigned FRAME_W    = 4;
	localparam int unsigned TLEFT_W    = 16;
	localparam int unsigned FCOUNT_W   = 5;

	localparam logic FUNC_TICK  = 1'b0;
	localparam logic FUNC_WRITE = 1'b1;

	typedef struct packed {
		logic                  func;
		logic [ELAPSED_W-1:0]  elapsed_ms;
		logic [WINDEX_W-1:0]   write_index;
		logic [WDUR_W-1:0]     write_duration;
	} req_t;

	typedef struct packed {
		logic [FRAME_W-1:0]    current_frame;
		logic [TLEFT_W-1:0]    time_left;
	} rsp_t;

endpackage

// ===== rtl/fst_table_mem.sv =====
// ----------------------------------------------------------------------------
// fst_table_mem: frame duration table
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module fst_table_mem #(
	parameter int unsigned DEPTH = fst_pkg::MAX_FRAMES_DEF,
	parameter int unsigned WIDTH = fst_pkg::DURATION_BITS_DEF,
	parameter int unsigned AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/fst_mod_unit.sv =====
// ----------------------------------------------------------------------------
// fst_mod_unit: iterative modulo unit
// Restoring remainder, one dividend bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module fst_mod_unit #(
	parameter int unsigned TOT_W = fst_pkg::DURATION_BITS_DEF + fst_pkg::FCOUNT_W
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [fst_pkg::ELAPSED_W-1:0]  dividend,
	input  logic [TOT_W-1:0]               divisor,
	output logic                           done,
	output logic [TOT_W-1:0]               rem
);

	localparam int unsigned CNT_W = $clog2(fst_pkg::ELAPSED_W + 1);

	logic                          run_q;
	logic [CNT_W-1:0]              bits_q;
	logic [fst_pkg::ELAPSED_W-1:0] num_q;
	logic [TOT_W-1:0]              div_q;
	logic [TOT_W-1:0]              rem_q;
	logic                          done_q;
	logic [TOT_W:0]                shifted;
	logic [TOT_W:0]                trial;
	logic [TOT_W-1:0]              rem_next;

	always_comb begin
		shifted  = {rem_q, num_q[fst_pkg::ELAPSED_W-1]};
		trial    = shifted - {1'b0, div_q};
		rem_next = (shifted >= {1'b0, div_q}) ? trial[TOT_W-1:0] : shifted[TOT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			bits_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q  <= 1'b1;
				bits_q <= CNT_W'(fst_pkg::ELAPSED_W);
			end else if (run_q) begin
				bits_q <= bits_q - 1'b1;
				if (bits_q == CNT_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			div_q <= divisor;
			rem_q <= '0;
		end else if (run_q) begin
			num_q <= {num_q[fst_pkg::ELAPSED_W-2:0], 1'b0};
			rem_q <= rem_next;
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

// ===== rtl/frame_sequence_timer.sv =====
// ----------------------------------------------------------------------------
// frame_sequence_timer: looping frame sequencer driven by elapsed time
// Duration table in memory, frame walk and lap skipping in a sequencer.
// ----------------------------------------------------------------------------
// Usage: raise start with a request word while busy is low. A write word
// (func = 1) stores one frame duration and answers on rsp in the next cycle.
// A tick word (func = 0) advances the sequence by elapsed_ms; with fewer
// than two frames configured it answers in the next cycle, unchanged.
// Otherwise the sequencer reloads the current frame's duration from the
// table and answers with the time left when the tick ends inside it. A tick
// that crosses a frame sums all durations, read from the table one entry
// per cycle, has the one-bit-per-cycle modulo unit skip whole laps, and
// then walks the remaining frames one by one on the table's read port.
// Every request yields exactly one response word, shown for one cycle while
// rsp_valid is high; the receiver cannot stall it. A duration of zero is
// used as 1. Write frame_count through cfg_* only while no request is in
// flight; cfg_ready is always high. Reading a table entry never written
// yields no defined time left.
// ----------------------------------------------------------------------------
module frame_sequence_timer #(
	parameter int unsigned MAX_FRAMES    = fst_pkg::MAX_FRAMES_DEF,
	parameter int unsigned DURATION_BITS = fst_pkg::DURATION_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  fst_pkg::req_t                 req,
	output logic                          rsp_valid,
	output fst_pkg::rsp_t                 rsp,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [fst_pkg::FCOUNT_W-1:0]  cfg_data
);

	localparam int unsigned FI_W  = $clog2(MAX_FRAMES);
	localparam int unsigned DB    = DURATION_BITS;
	localparam int unsigned TOT_W = DURATION_BITS + fst_pkg::FCOUNT_W;
	localparam int unsigned EW    = fst_pkg::ELAPSED_W;
	localparam int unsigned CW    = fst_pkg::FCOUNT_W;

	typedef enum logic [3:0] {
		S_IDLE,
		S_RELOAD_RD,
		S_RELOAD,
		S_SUM,
		S_SUM_LAST,
		S_DIVGO,
		S_DIV,
		S_WALK_RD,
		S_WALK,
		S_DONE
	} state_t;

	state_t            state_q;
	logic [CW-1:0]     frame_count_q;
	logic [CW-1:0]     cnt_q;
	logic [FI_W-1:0]   frame_q;
	logic [DB-1:0]     left_q;
	logic [EW-1:0]     t_q;
	logic [FI_W-1:0]   idx_q;
	logic [TOT_W-1:0]  total_q;
	logic              acc_s1;
	fst_pkg::rsp_t     rsp_q;
	logic              rsp_valid_q;

	logic              accept;
	logic [CW-1:0]     cnt_eff;
	logic              mem_we;
	logic              mem_re;
	logic [FI_W-1:0]   mem_raddr;
	logic [DB-1:0]     mem_rdata;
	logic [DB-1:0]     rd_dur;
	logic [DB-1:0]     left_eff;
	logic [FI_W-1:0]   frame_next;
	logic              div_start;
	logic              div_done;
	logic [TOT_W-1:0]  div_rem;

	// Configuration is a single register; always take the word.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_count_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			frame_count_q <= cfg_data;
		end
	end

	assign accept = start && !busy;
	assign busy   = (state_q != S_IDLE);

	// Clamp the configured count to the table depth.
	assign cnt_eff = (32'(frame_count_q) > MAX_FRAMES) ? CW'(MAX_FRAMES) : frame_count_q;

	// Drop writes that fall outside the table.
	assign mem_we = accept && (req.func == fst_pkg::FUNC_WRITE) &&
	                (32'(req.write_index) < MAX_FRAMES);

	// The read port serves the reload, the lap sum and the frame walk.
	assign mem_re    = (state_q == S_RELOAD_RD) || (state_q == S_SUM) ||
	                   (state_q == S_WALK_RD);
	assign mem_raddr = (state_q == S_SUM) ? idx_q : frame_q;

	fst_table_mem #(
		.DEPTH (MAX_FRAMES),
		.WIDTH (DB),
		.AW    (FI_W)
	) u_table (
		.clk   (clk),
		.we    (mem_we),
		.waddr (FI_W'(req.write_index)),
		.wdata (DB'(req.write_duration)),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// A zero duration counts as one millisecond.
	assign rd_dur     = (mem_rdata == '0) ? DB'(1) : mem_rdata;
	assign left_eff   = (left_q == '0) ? rd_dur : left_q;
	assign frame_next = (32'(frame_q) + 1 >= 32'(cnt_q)) ? '0 : frame_q + 1'b1;

	assign div_start = (state_q == S_DIVGO);

	fst_mod_unit #(
		.TOT_W (TOT_W)
	) u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (t_q),
		.divisor  (total_q),
		.done     (div_done),
		.rem      (div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			frame_q     <= '0;
			left_q      <= '0;
			rsp_valid_q <= 1'b0;
			acc_s1      <= 1'b0;
		end else begin
			rsp_valid_q <= 1'b0;
			acc_s1      <= (state_q == S_SUM);
			// Accumulate the lap total one read behind the address.
			if (acc_s1) begin
				total_q <= total_q + TOT_W'(rd_dur);
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						t_q   <= req.elapsed_ms;
						cnt_q <= cnt_eff;
						if (req.func == fst_pkg::FUNC_WRITE || cnt_eff <= CW'(1)) begin
							// Answer with the state as it stands.
							rsp_q.current_frame <= fst_pkg::FRAME_W'(frame_q);
							rsp_q.time_left     <= fst_pkg::TLEFT_W'(left_q);
							rsp_valid_q         <= 1'b1;
						end else begin
							// Restart an out-of-range frame with an empty counter.
							if (32'(frame_q) >= 32'(cnt_eff)) begin
								frame_q <= '0;
								left_q  <= '0;
							end
							state_q <= S_RELOAD_RD;
						end
					end
				end
				S_RELOAD_RD: begin
					state_q <= S_RELOAD;
				end
				S_RELOAD: begin
					if (t_q >= EW'(left_eff)) begin
						t_q     <= t_q - EW'(left_eff);
						frame_q <= frame_next;
						idx_q   <= '0;
						total_q <= '0;
						state_q <= S_SUM;
					end else begin
						left_q  <= left_eff - DB'(t_q);
						state_q <= S_DONE;
					end
				end
				S_SUM: begin
					if (32'(idx_q) + 1 == 32'(cnt_q)) begin
						state_q <= S_SUM_LAST;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_SUM_LAST: begin
					state_q <= S_DIVGO;
				end
				S_DIVGO: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_done) begin
						t_q     <= EW'(div_rem);
						state_q <= S_WALK_RD;
					end
				end
				S_WALK_RD: begin
					state_q <= S_WALK;
				end
				S_WALK: begin
					if (t_q >= EW'(rd_dur)) begin
						t_q     <= t_q - EW'(rd_dur);
						frame_q <= frame_next;
						state_q <= S_WALK_RD;
					end else begin
						left_q  <= rd_dur - DB'(t_q);
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					rsp_q.current_frame <= fst_pkg::FRAME_W'(frame_q);
					rsp_q.time_left     <= fst_pkg::TLEFT_W'(left_q);
					rsp_valid_q         <= 1'b1;
					state_q             <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef ASSERT_OFF
	// A write request answers on the next cycle.
	a_write_answers: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (req.func == fst_pkg::FUNC_WRITE) |=> rsp_valid)
		else $error("write request not answered next cycle");

	// A finished tick always leaves time in the current frame.
	a_left_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE) |-> (left_q != '0))
		else $error("tick finished with no time left");

	// The current frame stays inside the sequence while a tick is worked.
	a_frame_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WALK || state_q == S_DONE) |-> (32'(frame_q) < 32'(cnt_q)))
		else $error("frame index beyond frame count");

	// The modulo unit reports only while the sequencer waits for it.
	a_div_done_owned: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_DIV))
		else $error("modulo result outside its wait state");
`endif

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the frame sequence timer
// Fills the duration table, then runs tick and write words through a
// bursty driver under several frame counts, including the out-of-range
// ones. A local predictor computes the frame and time left expected from
// each accepted word, and the monitor checks every response strobe.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int unsigned TABLE_DEPTH  = fst_pkg::MAX_FRAMES_DEF;
	localparam int unsigned RANDOM_WORDS = 1400;
	localparam int unsigned REQ_W        = $bits(fst_pkg::req_t);

	logic                         clk       = 1'b0;
	logic                         arst_n    = 1'b0;
	logic                         start     = 1'b0;
	logic                         busy;
	fst_pkg::req_t                req       = '0;
	logic                         rsp_valid;
	fst_pkg::rsp_t                rsp;
	logic                         cfg_valid = 1'b0;
	logic                         cfg_ready;
	logic [fst_pkg::FCOUNT_W-1:0] cfg_data  = '0;

	// Words waiting for the driver, and responses owed by the block, oldest first
	fst_pkg::req_t words_to_send[$];
	fst_pkg::rsp_t frame_reports_due[$];

	// Predictor state: duration table, shown frame, time left, frame count
	logic [fst_pkg::WDUR_W-1:0]   dur_table [TABLE_DEPTH];
	int unsigned                  frame_shown = 0;
	longint unsigned              left_shown  = 0;
	logic [fst_pkg::FCOUNT_W-1:0] frame_count_model = '0;

	int unsigned   mismatches = 0;
	int unsigned   burst_left = 1;
	int unsigned   gap_left   = 0;
	fst_pkg::rsp_t predicted;
	fst_pkg::rsp_t wanted;

	frame_sequence_timer u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp      (rsp),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	always #5 clk = ~clk;

	// A stored duration of zero counts as one millisecond
	function automatic longint unsigned frame_length(int unsigned idx);
		longint unsigned d;
		d = dur_table[idx[fst_pkg::WINDEX_W-1:0]];
		return (d == 0) ? 1 : d;
	endfunction

	// Wrap to frame 0 past the last frame of the loop
	function automatic int unsigned following_frame(int unsigned f, int unsigned loop_len);
		return (f + 1 >= loop_len) ? 0 : f + 1;
	endfunction

	// Apply one accepted word to the predicted state and return the response it owes
	task automatic advance_frames(input fst_pkg::req_t w, output fst_pkg::rsp_t r);
		longint unsigned t;
		longint unsigned lap;
		int unsigned     loop_len;
		if (w.func == fst_pkg::FUNC_WRITE) begin
			dur_table[w.write_index] = w.write_duration;
		end else begin
			// Clamp an oversized count to the table depth
			loop_len = (frame_count_model > TABLE_DEPTH) ? TABLE_DEPTH : frame_count_model;
			// Hold the state when the loop has fewer than two frames
			if (loop_len >= 2) begin
				t = w.elapsed_ms;
				// Restart a frame that fell outside a shrunk loop, with an empty counter
				if (frame_shown >= loop_len) begin
					frame_shown = 0;
					left_shown  = 0;
				end
				if (left_shown == 0)
					left_shown = frame_length(frame_shown);
				if (t >= left_shown) begin
					t -= left_shown;
					frame_shown = following_frame(frame_shown, loop_len);
					left_shown  = frame_length(frame_shown);
					// Drop whole laps, then walk the remainder frame by frame
					lap = 0;
					for (int unsigned i = 0; i < loop_len; i++)
						lap += frame_length(i);
					t %= lap;
					while (t >= left_shown) begin
						t -= left_shown;
						frame_shown = following_frame(frame_shown, loop_len);
						left_shown  = frame_length(frame_shown);
					end
				end
				left_shown -= t;
			end
		end
		r.current_frame = frame_shown[fst_pkg::FRAME_W-1:0];
		r.time_left     = left_shown[fst_pkg::TLEFT_W-1:0];
	endtask

	function automatic fst_pkg::req_t tick_word(input logic [fst_pkg::ELAPSED_W-1:0] elapsed);
		fst_pkg::req_t w;
		w                = REQ_W'({$urandom(), $urandom()});
		w.func           = fst_pkg::FUNC_TICK;
		w.elapsed_ms     = elapsed;
		return w;
	endfunction

	function automatic fst_pkg::req_t write_word(input logic [fst_pkg::WINDEX_W-1:0] idx,
						     input logic [fst_pkg::WDUR_W-1:0] dur);
		fst_pkg::req_t w;
		w                = REQ_W'({$urandom(), $urandom()});
		w.func           = fst_pkg::FUNC_WRITE;
		w.write_index    = idx;
		w.write_duration = dur;
		return w;
	endfunction

	// A quarter are writes; mostly short ticks over a few frames, now and then 32-bit
	function automatic fst_pkg::req_t random_word();
		fst_pkg::req_t w;
		int unsigned   pick;
		w.func        = ($urandom_range(0, 3) == 0) ? fst_pkg::FUNC_WRITE : fst_pkg::FUNC_TICK;
		w.write_index = fst_pkg::WINDEX_W'($urandom_range(0, TABLE_DEPTH - 1));
		pick = $urandom_range(0, 9);
		if (pick < 4)
			w.elapsed_ms = $urandom_range(0, 6);
		else if (pick < 7)
			w.elapsed_ms = $urandom_range(0, 100);
		else if (pick < 9)
			w.elapsed_ms = $urandom_range(0, 5000);
		else
			w.elapsed_ms = $urandom();
		pick = $urandom_range(0, 9);
		if (pick < 6)
			w.write_duration = fst_pkg::WDUR_W'($urandom_range(0, 12));
		else if (pick < 9)
			w.write_duration = fst_pkg::WDUR_W'($urandom_range(0, 400));
		else
			w.write_duration = fst_pkg::WDUR_W'($urandom_range(0, 65535));
		return w;
	endfunction

	// Driver: hold start until busy is low, then advance through bursts and gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start      <= 1'b0;
			req        <= '0;
			burst_left <= 1;
			gap_left   <= 0;
		end else begin
			if (start && !busy) begin
				advance_frames(req, predicted);
				frame_reports_due.push_back(predicted);
			end
			if (start && busy) begin
				// hold the word until the block takes it
			end else if (gap_left != 0) begin
				start    <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (words_to_send.size() != 0) begin
				start <= 1'b1;
				req   <= words_to_send.pop_front();
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 24);
					// Leave about a quarter of the bursts back to back
					gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Monitor: every strobe retires the oldest expected word
	always @(posedge clk) begin
		if (arst_n && rsp_valid === 1'b1) begin
			if (frame_reports_due.size() == 0) begin
				$display("%0t: unexpected response word: frame %0d, time left %0d",
					 $time, rsp.current_frame, rsp.time_left);
				mismatches++;
			end else begin
				wanted = frame_reports_due.pop_front();
				if (rsp.current_frame !== wanted.current_frame) begin
					$display("%0t: current_frame expected %0d, got %0d",
						 $time, wanted.current_frame, rsp.current_frame);
					mismatches++;
				end
				if (rsp.time_left !== wanted.time_left) begin
					$display("%0t: time_left expected %0d, got %0d",
						 $time, wanted.time_left, rsp.time_left);
					mismatches++;
				end
			end
		end
	end

	// Wait until every queued word is taken, answered, and the block is idle
	task automatic wait_drained();
		while (words_to_send.size() != 0 || start || busy || frame_reports_due.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_frame_count(input logic [fst_pkg::FCOUNT_W-1:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do
			@(posedge clk);
		while (cfg_ready !== 1'b1);
		cfg_valid <= 1'b0;
		frame_count_model = value;
		@(negedge clk);
	endtask

	initial begin : stimulus
		int unsigned                  queued;
		logic [fst_pkg::FCOUNT_W-1:0] count_pick;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Frame count is zero out of reset: ticks leave the state alone
		words_to_send.push_back(tick_word('0));
		words_to_send.push_back(tick_word('1));
		// Fill the whole table first so no tick reads an unwritten entry;
		// entry 0 holds a zero duration, the last entry the longest one
		for (int unsigned i = 0; i < TABLE_DEPTH; i++)
			words_to_send.push_back(write_word(fst_pkg::WINDEX_W'(i),
				(i == 0) ? 16'h0000 :
				(i == TABLE_DEPTH - 1) ? 16'hFFFF : fst_pkg::WDUR_W'(i + 2)));
		wait_drained();

		// One frame: still a short sequence
		write_frame_count(fst_pkg::FCOUNT_W'(1));
		words_to_send.push_back(tick_word(5));
		wait_drained();

		// Two frames: reload on an empty counter, exact frame end, a huge tick
		write_frame_count(fst_pkg::FCOUNT_W'(2));
		words_to_send.push_back(tick_word(0));
		words_to_send.push_back(tick_word(1));
		words_to_send.push_back(tick_word('1));
		wait_drained();

		// Counts above the table depth clamp to it
		write_frame_count(fst_pkg::FCOUNT_W'(17));
		words_to_send.push_back(tick_word(7));
		words_to_send.push_back(tick_word(100));
		wait_drained();
		write_frame_count(fst_pkg::FCOUNT_W'(31));
		words_to_send.push_back(tick_word(1000));
		wait_drained();

		// Full loop, landing far into the table
		write_frame_count(fst_pkg::FCOUNT_W'(16));
		words_to_send.push_back(tick_word('1));
		words_to_send.push_back(tick_word(12345));
		wait_drained();

		// Shrink the loop below the shown frame: it restarts at frame 0
		write_frame_count(fst_pkg::FCOUNT_W'(3));
		words_to_send.push_back(tick_word(2));
		wait_drained();
		write_frame_count(fst_pkg::FCOUNT_W'(0));
		words_to_send.push_back(tick_word(9));
		wait_drained();

		// Random phases, mostly with a real loop of two or more frames
		queued = 0;
		while (queued < RANDOM_WORDS) begin
			count_pick = fst_pkg::FCOUNT_W'(($urandom_range(0, 9) < 7) ?
				$urandom_range(2, 16) : $urandom_range(0, 31));
			write_frame_count(count_pick);
			repeat ($urandom_range(60, 160)) begin
				words_to_send.push_back(random_word());
				queued++;
			end
			wait_drained();
		end

		repeat (50) @(posedge clk);
		if (mismatches == 0 && frame_reports_due.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// Watchdog: several times the slowest legal run
	initial begin : watchdog
		#10_000_000;
		$display("%0t: timeout, %0d words unsent, %0d responses outstanding",
			 $time, words_to_send.size(), frame_reports_due.size());
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
